// ----- rtl/core/decimated_trace_capture_macros.svh -----
// Assertion macros used by the checker of the trace recorder.
`ifndef DECIMATED_TRACE_CAPTURE_MACROS_SVH
`define DECIMATED_TRACE_CAPTURE_MACROS_SVH

// Implication whose consequent is checked in the clock after the antecedent.
`define DTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked in the same clock as the antecedent.
`define DTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/dtc_pkg.sv -----
`default_nettype none
package dtc_pkg;

  localparam int ROWS          = 128;
  localparam int CHANNELS      = 8;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int CH_W          = $clog2(CHANNELS);
  localparam int SAMPLE_W      = 32;
  localparam int RATIO_W       = 16;
  localparam int ENABLE_W      = 8;
  localparam int ROWPTR_W      = 8;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SINGLE = 3'd1,
    ACT_LIVE   = 3'd2,
    ACT_HALT   = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_LIVE   = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

endpackage
`default_nettype wire

// ----- rtl/core/decimated_trace_capture.sv -----
// Multi-channel trace recorder. A request is accepted at a rising edge where
// start is high and busy is low, and its result appears on the result ports
// for exactly one cycle, marked by result_valid, in the cycle right after
// acceptance. The receiver cannot hold results off, and none is needed: a
// new request may be accepted on every clock, so the sustained rate is one
// request per cycle. Busy is high only during reset and in the first cycle
// after it. A tick request captures all enabled channels of one row at once,
// because the trace store is a single memory with one row of all channels
// per word and a write enable per channel lane; a read request reads one row
// from that memory, whose registered output is narrowed to the requested
// channel. Configuration writes are taken on every cycle outside reset and
// must only be issued while no request is in flight. Entries of the trace
// store that were never written read back as undefined data.
`default_nettype none
module decimated_trace_capture import dtc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Request channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            action,
  input  wire logic [6:0]            read_row,
  input  wire logic [2:0]            read_channel,
  input  wire logic [SAMPLE_W-1:0]   sample_0,
  input  wire logic [SAMPLE_W-1:0]   sample_1,
  input  wire logic [SAMPLE_W-1:0]   sample_2,
  input  wire logic [SAMPLE_W-1:0]   sample_3,
  input  wire logic [SAMPLE_W-1:0]   sample_4,
  input  wire logic [SAMPLE_W-1:0]   sample_5,
  input  wire logic [SAMPLE_W-1:0]   sample_6,
  input  wire logic [SAMPLE_W-1:0]   sample_7,
  // Result channel.
  output logic                       result_valid,
  output logic [SAMPLE_W-1:0]        read_value,
  output logic [ROWPTR_W-1:0]        write_row,
  output logic [1:0]                 mode_now,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [RATIO_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [RATIO_W-1:0]  decimation_ratio;
  logic [ENABLE_W-1:0] channel_enable;

  // Recorder state.
  logic [RATIO_W-1:0]  tick_count, tick_count_next;
  logic [ROWPTR_W-1:0] row_pointer, row_pointer_next;
  mode_t               capture_mode, capture_mode_next;

  // Trace store: one word per row holding every channel side by side.
  logic [CHANNELS*SAMPLE_W-1:0] trace_mem [ROWS];
  logic [CHANNELS*SAMPLE_W-1:0] rd_data;
  logic                         rd_pending;
  logic [CH_W-1:0]              rd_channel;

  logic                         busy_q;
  logic                         accept;
  logic                         cfg_write;
  logic                         capture;
  logic [RATIO_W-1:0]           tick_inc;
  logic                         rd_en;
  logic [SAMPLE_W-1:0]          samples [CHANNELS];

  assign busy      = busy_q | rst;
  assign accept    = start & ~busy;
  assign cfg_ready = ~rst;
  assign cfg_write = cfg_valid & cfg_ready;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  assign tick_inc = tick_count + RATIO_W'(1);

  // Next-state logic for one accepted request. A tick while armed bumps the
  // counter; the first tick of a period captures the current row, and the
  // end of the period advances the row (ratio zero ends every period).
  always_comb begin
    tick_count_next   = tick_count;
    row_pointer_next  = row_pointer;
    capture_mode_next = capture_mode;
    capture           = 1'b0;
    rd_en             = 1'b0;
    if (accept) begin
      case (action_t'(action))
        ACT_TICK: begin
          if (capture_mode != MODE_IDLE) begin
            tick_count_next = tick_inc;
            capture = (tick_inc == RATIO_W'(1)) && (int'(row_pointer) < ROWS);
            if (tick_inc >= decimation_ratio) begin
              tick_count_next = '0;
              if (capture_mode == MODE_SINGLE) begin
                row_pointer_next = row_pointer + ROWPTR_W'(1);
                if (int'(row_pointer_next) >= ROWS) begin
                  capture_mode_next = MODE_IDLE;
                end
              end else begin
                row_pointer_next = (int'(row_pointer) < ROWS - 1) ?
                                   row_pointer + ROWPTR_W'(1) : '0;
              end
            end
          end
        end
        ACT_SINGLE: begin
          tick_count_next   = '0;
          row_pointer_next  = '0;
          capture_mode_next = MODE_SINGLE;
        end
        ACT_LIVE: begin
          tick_count_next   = '0;
          row_pointer_next  = '0;
          capture_mode_next = MODE_LIVE;
        end
        ACT_HALT: begin
          capture_mode_next = MODE_IDLE;
        end
        ACT_READ: begin
          rd_en = (int'(read_row) < ROWS) && (int'(read_channel) < CHANNELS);
        end
        default: begin
        end
      endcase
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q           <= 1'b1;
      result_valid     <= 1'b0;
      rd_pending       <= 1'b0;
      tick_count       <= '0;
      row_pointer      <= '0;
      capture_mode     <= MODE_IDLE;
      decimation_ratio <= RATIO_W'(1);
      channel_enable   <= '1;
    end else begin
      busy_q       <= 1'b0;
      result_valid <= accept;
      if (accept) begin
        rd_pending <= rd_en;
      end
      tick_count   <= tick_count_next;
      row_pointer  <= row_pointer_next;
      capture_mode <= capture_mode_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_RATIO:  decimation_ratio <= cfg_data;
          CFG_ENABLE: channel_enable   <= cfg_data[ENABLE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Trace store: lane-enabled row write on capture, registered row read.
  always_ff @(posedge clk) begin
    if (capture) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (channel_enable[c]) begin
          trace_mem[row_pointer[ROW_W-1:0]][c*SAMPLE_W +: SAMPLE_W] <= samples[c];
        end
      end
    end
    if (rd_en) begin
      rd_data    <= trace_mem[read_row[ROW_W-1:0]];
      rd_channel <= read_channel[CH_W-1:0];
    end
  end

  // The state registers already hold the post-request values during the
  // result cycle, so they drive the result ports directly.
  assign read_value = rd_pending ? rd_data[rd_channel*SAMPLE_W +: SAMPLE_W] : '0;
  assign write_row  = row_pointer;
  assign mode_now   = capture_mode;

endmodule
`default_nettype wire

// ----- rtl/core/dtc_checker.sv -----
`default_nettype none
`include "decimated_trace_capture_macros.svh"
module dtc_checker import dtc_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [2:0]          action,
  input wire logic                result_valid,
  input wire logic [SAMPLE_W-1:0] read_value,
  input wire logic [ROWPTR_W-1:0] write_row,
  input wire logic [1:0]          mode_now
);

  // Every accepted request yields exactly one result, in the following cycle.
  `DTC_ASSERT_NEXT(a_result_follows, start && !busy, result_valid)
  `DTC_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !result_valid)

  // A single-capture start always reports row zero and single mode.
  `DTC_ASSERT_NEXT(a_single_start, start && !busy && action == ACT_SINGLE,
                   mode_now == MODE_SINGLE && write_row == '0)

  // Only read requests carry a stored word.
  `DTC_ASSERT_NEXT(a_zero_unless_read, start && !busy && action != ACT_READ,
                   read_value == '0)

  // The recorder only ever reports a defined mode.
  `DTC_ASSERT_NOW(a_mode_defined, result_valid,
                  mode_now == MODE_IDLE || mode_now == MODE_SINGLE ||
                  mode_now == MODE_LIVE)

endmodule

bind decimated_trace_capture dtc_checker u_dtc_checker (.*);
`default_nettype wire
